// ===== rtl/core/rbf_pkg.sv =====
// rbf_pkg: shared constants and types for the receive byte fifo with flow control
// depends on nothing; imported by rbf_ring, rx_byte_fifo_flow_control_top and the testbench

package rbf_pkg;

  // ring geometry
  localparam int unsigned RingDepth = 1024;
  localparam int unsigned IdxW      = $clog2(RingDepth);
  localparam int unsigned CntW      = $clog2(RingDepth + 1);

  // field and register widths
  localparam int unsigned ByteW     = 8;
  localparam int unsigned WmW       = 10;
  localparam int unsigned DelayW    = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CmpW      = (CntW > WmW) ? CntW : WmW;

  // register reset values
  localparam logic [WmW-1:0]    StopWmReset     = WmW'(64);
  localparam logic [DelayW-1:0] StartDelayReset = DelayW'(5000);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgStopWm     = 1'b0,
    CfgStartDelay = 1'b1
  } cfg_reg_e;

  // request kinds
  typedef enum logic {
    FuncPut     = 1'b0,
    FuncService = 1'b1
  } func_e;

  // control from the top level to the ring
  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

  // status from the ring to the top level
  typedef struct packed {
    logic            empty;
    logic            full;
    logic [CntW-1:0] free_space;
  } ring_status_t;

endpackage

// ===== rtl/core/rx_byte_fifo_flow_control_top.sv =====
// rx_byte_fifo_flow_control_top: receive byte fifo with stop-line flow control and delayed drain
// the result of a request is strobed on done_o in the cycle after start is taken
// a new request is not taken while a result is strobed, as busy is held high in the result cycle
// busy is high during the result cycle; the receiver cannot stall results
// reset clears indices, fill count, stop line, drain mode and time mark, and returns the
// config registers to their reset values; the ring memory itself is not cleared
// depends on rbf_pkg and rbf_ring

module rx_byte_fifo_flow_control_top import rbf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // request channel
  input  logic                start,
  output logic                busy,
  input  logic                func_i,
  input  logic [ByteW-1:0]    data_byte_i,
  input  logic [TimeW-1:0]    time_now_i,
  // result channel
  output logic                done_o,
  output logic                byte_valid_o,
  output logic [ByteW-1:0]    byte_out_o,
  output logic                flow_stop_o,
  output logic                overflow_o,
  output logic                draining_o
);

  logic [WmW-1:0]    stop_wm_q;
  logic [DelayW-1:0] start_delay_q;
  logic              stop_q, stop_d;
  logic              drain_q, drain_d;
  logic [TimeW-1:0]  idle_q, idle_d;
  logic              pend_q;
  logic              valid_q, valid_d;
  logic              ovf_q, ovf_d;
  logic              accept;
  logic [TimeW-1:0]  elapsed;
  logic [CmpW-1:0]   free_ext;
  logic [CmpW-1:0]   wm_ext;
  ring_cmd_t         ring_cmd;
  ring_status_t      ring_st;
  logic [ByteW-1:0]  ring_rdata;

  assign accept   = start && !busy;
  assign elapsed  = time_now_i - idle_q;
  assign free_ext = CmpW'(ring_st.free_space);
  assign wm_ext   = CmpW'(stop_wm_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_wm_q     <= StopWmReset;
      start_delay_q <= StartDelayReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgStopWm:     stop_wm_q     <= cfg_wdata_i[WmW-1:0];
        CfgStartDelay: start_delay_q <= cfg_wdata_i[DelayW-1:0];
        default:       ;
      endcase
    end
  end

  // request decode: stop line, drain mode, ring push and pop
  always_comb begin
    stop_d   = stop_q;
    drain_d  = drain_q;
    idle_d   = idle_q;
    valid_d  = 1'b0;
    ovf_d    = 1'b0;
    ring_cmd = '0;
    if (accept) begin
      unique case (func_e'(func_i))
        FuncPut: begin
          if (!stop_q && (free_ext <= wm_ext)) begin
            stop_d = 1'b1;
          end
          if (ring_st.full) begin
            ovf_d = 1'b1;
          end else begin
            ring_cmd.push = 1'b1;
          end
        end
        FuncService: begin
          if (stop_q && (free_ext > wm_ext)) begin
            stop_d = 1'b0;
          end
          if (ring_st.empty) begin
            drain_d = 1'b0;
            idle_d  = time_now_i;
          end else if (!drain_q) begin
            if (elapsed >= TimeW'(start_delay_q)) begin
              drain_d = 1'b1;
            end
          end else begin
            ring_cmd.pop = 1'b1;
            valid_d      = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q  <= 1'b0;
      drain_q <= 1'b0;
      idle_q  <= '0;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      stop_q  <= stop_d;
      drain_q <= drain_d;
      idle_q  <= idle_d;
      pend_q  <= accept;
      valid_q <= valid_d;
      ovf_q   <= ovf_d;
    end
  end

  // byte ring
  rbf_ring u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (ring_cmd),
    .wdata_i  (data_byte_i),
    .status_o (ring_st),
    .rdata_o  (ring_rdata)
  );

  // result outputs
  assign busy         = pend_q;
  assign done_o       = pend_q;
  assign byte_valid_o = pend_q && valid_q;
  assign byte_out_o   = (pend_q && valid_q) ? ring_rdata : '0;
  assign flow_stop_o  = stop_q;
  assign overflow_o   = pend_q && ovf_q;
  assign draining_o   = drain_q;

  // every accepted request gives a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> done_o)
    else $error("no result after an accepted request");

  // a byte is only popped while the drain mode is on
  assert property (@(posedge clk_i) disable iff (!rst_ni) byte_valid_o |-> draining_o)
    else $error("byte popped outside drain mode");

  // a put on a full ring is flagged and never pushed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func_i == FuncPut) && ring_st.full) |-> (!ring_cmd.push ##1 overflow_o))
    else $error("put on full ring not flagged");

  // the ring always keeps one free entry
  assert property (@(posedge clk_i) disable iff (!rst_ni) ring_st.free_space != '0)
    else $error("ring fill count beyond capacity");

endmodule

// ===== rtl/core/rbf_ring.sv =====
// rbf_ring: byte ring with one synchronous memory, write/read indices and fill count
// depends on rbf_pkg

module rbf_ring import rbf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ring_cmd_t        cmd_i,
  input  logic [ByteW-1:0] wdata_i,
  output ring_status_t     status_o,
  output logic [ByteW-1:0] rdata_o
);

  logic [ByteW-1:0] mem_q [RingDepth];
  logic [ByteW-1:0] rdata_q;
  logic [IdxW-1:0]  wr_idx_q, wr_idx_d;
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d;
  logic [CntW-1:0]  count_q, count_d;

  // index advance with wrap at the ring depth
  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    count_d  = count_q;
    if (cmd_i.push) begin
      wr_idx_d = (wr_idx_q == IdxW'(RingDepth - 1)) ? '0 : wr_idx_q + IdxW'(1);
    end
    if (cmd_i.pop) begin
      rd_idx_d = (rd_idx_q == IdxW'(RingDepth - 1)) ? '0 : rd_idx_q + IdxW'(1);
    end
    if (cmd_i.push && !cmd_i.pop) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop && !cmd_i.push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      count_q  <= '0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      count_q  <= count_d;
    end
  end

  // byte store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[wr_idx_q] <= wdata_i;
    end
    if (cmd_i.pop) begin
      rdata_q <= mem_q[rd_idx_q];
    end
  end

  // status, free space reads as full depth when empty
  assign status_o.empty      = (count_q == '0);
  assign status_o.full       = (count_q == CntW'(RingDepth - 1));
  assign status_o.free_space = CntW'(RingDepth) - count_q;
  assign rdata_o             = rdata_q;

endmodule

// ===== sim/tb_rx_byte_fifo_flow_control_top.sv =====
// testbench for rx_byte_fifo_flow_control_top: directed and random requests, checked per result
// depends on rbf_pkg and the rtl of rx_byte_fifo_flow_control_top
`timescale 1ns / 1ps

import rbf_pkg::*;

// one result as the block reports it
typedef struct {
  logic             byte_valid;
  logic [ByteW-1:0] byte_out;
  logic             flow_stop;
  logic             overflow;
  logic             draining;
} rx_result_t;

// ring, stop line and drain predictor with a queue of expected results
class rx_fifo_scoreboard;
  logic [ByteW-1:0]  ring_mem [RingDepth];
  int unsigned       wr_ptr;
  int unsigned       rd_ptr;
  logic              stop_line;
  logic              drain_on;
  logic [TimeW-1:0]  idle_mark;
  logic [WmW-1:0]    stop_wm;
  logic [DelayW-1:0] start_delay;
  rx_result_t        expected_q[$];
  int                errors;

  function new();
    wr_ptr      = 0;
    rd_ptr      = 0;
    stop_line   = 1'b0;
    drain_on    = 1'b0;
    idle_mark   = '0;
    stop_wm     = StopWmReset;
    start_delay = StartDelayReset;
    errors      = 0;
  endfunction

  function int unsigned fill_level();
    return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : RingDepth - rd_ptr + wr_ptr;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void set_config(cfg_reg_e idx, logic [CfgDataW-1:0] value);
    case (idx)
      CfgStopWm:     stop_wm = value[WmW-1:0];
      CfgStartDelay: start_delay = value[DelayW-1:0];
      default: ;
    endcase
  endfunction

  // work out the result of an accepted request and queue it
  function void note_request(func_e kind, logic [ByteW-1:0] data, logic [TimeW-1:0] now_val);
    rx_result_t       res;
    logic [TimeW-1:0] elapsed;
    res = '{byte_valid: 1'b0, byte_out: '0, flow_stop: 1'b0, overflow: 1'b0, draining: 1'b0};
    if (kind == FuncPut) begin
      if (!stop_line && (RingDepth - fill_level()) <= stop_wm) stop_line = 1'b1;
      if (fill_level() >= RingDepth - 1) begin
        res.overflow = 1'b1;
      end else begin
        ring_mem[wr_ptr] = data;
        wr_ptr = (wr_ptr + 1) % RingDepth;
      end
    end else begin
      if (stop_line && (RingDepth - fill_level()) > stop_wm) stop_line = 1'b0;
      if (rd_ptr == wr_ptr) begin
        drain_on  = 1'b0;
        idle_mark = now_val;
      end else if (!drain_on) begin
        elapsed = now_val - idle_mark;
        if (elapsed >= start_delay) drain_on = 1'b1;
      end else begin
        res.byte_valid = 1'b1;
        res.byte_out   = ring_mem[rd_ptr];
        rd_ptr = (rd_ptr + 1) % RingDepth;
      end
    end
    res.flow_stop = stop_line;
    res.draining  = drain_on;
    expected_q.push_back(res);
  endfunction

  function void compare_field(string name, logic [ByteW-1:0] exp_v, logic [ByteW-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h actual %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // compare a strobed result with the oldest expectation
  function void check_result(rx_result_t act);
    rx_result_t exp_r;
    if (expected_q.size() == 0) begin
      $error("result strobed with no request outstanding");
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    compare_field("byte_valid", exp_r.byte_valid, act.byte_valid);
    compare_field("byte_out", exp_r.byte_out, act.byte_out);
    compare_field("flow_stop", exp_r.flow_stop, act.flow_stop);
    compare_field("overflow", exp_r.overflow, act.overflow);
    compare_field("draining", exp_r.draining, act.draining);
  endfunction
endclass

module tb_rx_byte_fifo_flow_control_top;

  localparam int QuietLimit = 4000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                start;
  logic                busy;
  logic                func_i;
  logic [ByteW-1:0]    data_byte_i;
  logic [TimeW-1:0]    time_now_i;
  logic                done_o;
  logic                byte_valid_o;
  logic [ByteW-1:0]    byte_out_o;
  logic                flow_stop_o;
  logic                overflow_o;
  logic                draining_o;

  rx_fifo_scoreboard sb;
  logic [TimeW-1:0]  sys_time;
  int                quiet_cycles;

  rx_byte_fifo_flow_control_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .data_byte_i  (data_byte_i),
    .time_now_i   (time_now_i),
    .done_o       (done_o),
    .byte_valid_o (byte_valid_o),
    .byte_out_o   (byte_out_o),
    .flow_stop_o  (flow_stop_o),
    .overflow_o   (overflow_o),
    .draining_o   (draining_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result('{byte_valid: byte_valid_o, byte_out: byte_out_o, flow_stop: flow_stop_o,
                        overflow: overflow_o, draining: draining_o});
    end
  end

  // count cycles with neither a request taken nor a result strobed
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("tb_rx_byte_fifo_flow_control_top NOT OK");
    $finish;
  end

  // present one request and hold it until the block takes it
  task automatic send_request(func_e kind, logic [ByteW-1:0] data, logic [TimeW-1:0] now_val);
    @(negedge clk_i);
    start       <= 1'b1;
    func_i      <= kind;
    data_byte_i <= data;
    time_now_i  <= now_val;
    do @(posedge clk_i); while (busy);
    sb.note_request(kind, data, now_val);
  endtask

  task automatic pause(int cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // hold off until every outstanding request has its result
  task automatic wait_results();
    pause(1);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_config(idx, value);
  endtask

  // random mix of puts and service calls sent in bursts
  task automatic run_phase(int count, int put_pct, int step, bit gaps);
    int               burst_left;
    func_e            kind;
    logic [TimeW-1:0] t;
    burst_left = $urandom_range(1, 20);
    for (int i = 0; i < count; i++) begin
      kind = ($urandom_range(0, 99) < put_pct) ? FuncPut : FuncService;
      sys_time += $urandom_range(0, step);
      // occasional stray time stamp
      t = ($urandom_range(0, 19) == 0) ? TimeW'($urandom) : sys_time;
      send_request(kind, ByteW'($urandom), t);
      burst_left--;
      if (burst_left == 0) begin
        if (gaps && $urandom_range(0, 39) == 0) wait_results();
        else if (gaps && $urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
        burst_left = $urandom_range(1, 20);
      end
    end
  endtask

  // stimulus
  initial begin
    logic [TimeW-1:0] fill_mark;
    sb          = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgStopWm;
    cfg_wdata_i = '0;
    start       = 1'b0;
    func_i      = FuncPut;
    data_byte_i = '0;
    time_now_i  = '0;
    sys_time    = 32'hFFFF_0000;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings, delay edge, pops, time wrap
    send_request(FuncService, 8'h00, 32'd0);
    send_request(FuncPut, 8'h00, 32'd0);
    send_request(FuncPut, 8'hFF, 32'hFFFF_FFFF);
    send_request(FuncPut, 8'hA5, 32'd0);
    send_request(FuncService, 8'h00, 32'd4999);
    send_request(FuncService, 8'hFF, 32'd5000);
    send_request(FuncService, 8'h00, 32'd5001);
    send_request(FuncService, 8'h00, 32'd5001);
    send_request(FuncService, 8'h00, 32'd5001);
    send_request(FuncService, 8'h00, 32'hFFFF_FFFF);
    send_request(FuncPut, 8'h5A, 32'd0);
    send_request(FuncService, 8'h00, 32'd4998);
    send_request(FuncService, 8'h00, 32'd4999);
    send_request(FuncService, 8'h00, 32'd5000);
    send_request(FuncService, 8'h00, 32'd123);
    wait_results();

    // widest watermark, no start delay, no idling
    write_cfg(CfgStopWm, 16'd1023);
    write_cfg(CfgStartDelay, 16'd0);
    run_phase(150, 55, 4, 1'b0);
    wait_results();

    // upper write bits beyond the watermark width are dropped
    write_cfg(CfgStopWm, 16'hFC20);
    write_cfg(CfgStartDelay, 16'd40);
    run_phase(200, 50, 8, 1'b1);
    wait_results();

    // zero watermark, longest delay
    write_cfg(CfgStopWm, 16'd0);
    write_cfg(CfgStartDelay, 16'hFFFF);
    run_phase(150, 50, 30000, 1'b1);
    wait_results();

    write_cfg(CfgStopWm, 16'($urandom));
    write_cfg(CfgStartDelay, 16'($urandom_range(0, 300)));
    run_phase(300, 50, 50, 1'b1);
    wait_results();

    // empty the ring before the fill run
    write_cfg(CfgStartDelay, 16'd0);
    while (sb.fill_level() != 0) begin
      sys_time += 1;
      send_request(FuncService, ByteW'($urandom), sys_time);
    end
    sys_time += 1;
    fill_mark = sys_time;
    send_request(FuncService, 8'h00, fill_mark);
    wait_results();

    // fill past full with the drain held back, then release it at the exact delay
    write_cfg(CfgStopWm, 16'($urandom_range(100, 900)));
    write_cfg(CfgStartDelay, 16'hFFFF);
    send_request(FuncPut, ByteW'($urandom), TimeW'($urandom));
    for (int i = 0; i < 1070; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        send_request(FuncService, ByteW'($urandom), fill_mark + $urandom_range(0, 60000));
      end else begin
        send_request(FuncPut, ByteW'($urandom), TimeW'($urandom));
      end
      if ($urandom_range(0, 15) == 0) pause($urandom_range(1, 5));
    end
    send_request(FuncService, 8'h00, fill_mark + 32'd65534);
    send_request(FuncService, 8'h00, fill_mark + 32'd65535);
    for (int i = 0; i < 80; i++) begin
      send_request(FuncService, ByteW'($urandom), TimeW'($urandom));
      if ($urandom_range(0, 7) == 0) pause($urandom_range(1, 4));
    end

    // let the last results arrive
    wait_results();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_rx_byte_fifo_flow_control_top OK");
    end else begin
      $display("tb_rx_byte_fifo_flow_control_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== rx_byte_fifo_flow_control_top.f =====
rtl/core/rbf_pkg.sv
rtl/core/rbf_ring.sv
rtl/core/rx_byte_fifo_flow_control_top.sv
sim/tb_rx_byte_fifo_flow_control_top.sv
